@@ rtl/ahs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ahs_pkg;

	localparam logic [63:0] AHS_IV_WORD0 = 64'h0000_0801_00CC_0002;
	localparam int AHS_ROUNDS = 12;
	localparam int AHS_RND_W = 4;
	localparam int AHS_CMD_DEPTH = 2;
	localparam logic [7:0] AHS_PAD_BYTE = 8'h01;
	localparam logic [1:0] AHS_LAST_INDEX = 2'd3;

	typedef logic [4:0][63:0] state_t;

	localparam state_t AHS_IV_STATE = {256'd0, AHS_IV_WORD0};

	typedef struct packed {
		logic fin;
		logic [63:0] block;
	} cmd_t;

	typedef struct packed {
		logic [63:0] digest;
		logic [1:0] index;
		logic last;
	} res_t;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	function automatic state_t ascon_round(input state_t s, input logic [AHS_RND_W-1:0] r);
		logic [63:0] x0, x1, x2, x3, x4;
		logic [63:0] t0, t1, t2, t3, t4;
		logic [7:0] rc;
		state_t o;
		rc = {4'hf - r, r};
		x0 = s[0];
		x1 = s[1];
		x2 = s[2] ^ {56'd0, rc};
		x3 = s[3];
		x4 = s[4];
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;
		o[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
		o[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
		o[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
		o[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
		o[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
		return o;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ahs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ahs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic         req_type,
	input  wire logic [7:0]   message_byte,
	input  wire logic         cmd_full,
	output logic              cmd_push,
	output ahs_pkg::cmd_t     cmd_data
);
	import ahs_pkg::*;

	logic [2:0] fill_q;
	logic [7:0][7:0] buf_q;
	logic [7:0][7:0] blk;
	logic accept;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_push = accept && (req_type || fill_q == 3'd7);

	// bytes below the fill point come from the buffer, the next one is new or the pad
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (3'(k) < fill_q) begin
				blk[k] = buf_q[k];
			end else if (3'(k) == fill_q) begin
				blk[k] = req_type ? AHS_PAD_BYTE : message_byte;
			end else begin
				blk[k] = 8'd0;
			end
		end
	end

	assign cmd_data.fin = req_type;
	assign cmd_data.block = blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
		end else if (accept) begin
			if (req_type || fill_q == 3'd7) begin
				fill_q <= 3'd0;
			end else begin
				fill_q <= fill_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req_type) begin
			buf_q[fill_q] <= message_byte;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ahs_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ahs_cmd_fifo #(
	parameter int DEPTH = ahs_pkg::AHS_CMD_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire ahs_pkg::cmd_t wr_data,
	output logic               full,
	output logic               rd_valid,
	output ahs_pkg::cmd_t      rd_data,
	input  wire logic          rd_en
);
	import ahs_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = cnt_q == CntW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ahs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ahs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire ahs_pkg::cmd_t cmd_data,
	output logic               cmd_pop,
	output logic               res_valid,
	output ahs_pkg::res_t      res_data,
	input  wire logic          res_pop
);
	import ahs_pkg::*;

	typedef enum logic [1:0] {S_INIT, S_IDLE, S_RUN, S_EMIT} bst_t;

	localparam logic [AHS_RND_W-1:0] LastRnd = AHS_RND_W'(AHS_ROUNDS - 1);

	bst_t state_q;
	state_t st_q;
	state_t rnd_out;
	logic [AHS_RND_W-1:0] rnd_q;
	logic fin_q;
	logic [1:0] blk_q;
	logic out_valid_q;
	res_t res_q;
	logic slot_free;

	assign rnd_out = ascon_round(st_q, rnd_q);
	assign slot_free = !out_valid_q || res_pop;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = out_valid_q;
	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			st_q <= AHS_IV_STATE;
			rnd_q <= '0;
			fin_q <= 1'b0;
			blk_q <= 2'd0;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (state_q == S_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					st_q <= rnd_out;
					if (rnd_q == LastRnd) begin
						rnd_q <= '0;
						state_q <= S_IDLE;
					end else begin
						rnd_q <= rnd_q + AHS_RND_W'(1);
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						st_q[0] <= st_q[0] ^ cmd_data.block;
						fin_q <= cmd_data.fin;
						blk_q <= 2'd0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					st_q <= rnd_out;
					if (rnd_q == LastRnd) begin
						rnd_q <= '0;
						state_q <= fin_q ? S_EMIT : S_IDLE;
					end else begin
						rnd_q <= rnd_q + AHS_RND_W'(1);
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						res_q.digest <= st_q[0];
						res_q.index <= blk_q;
						res_q.last <= blk_q == AHS_LAST_INDEX;
						if (blk_q == AHS_LAST_INDEX) begin
							st_q <= AHS_IV_STATE;
							state_q <= S_INIT;
						end else begin
							blk_q <= blk_q + 2'd1;
							state_q <= S_RUN;
						end
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ascon_hash256_sponge_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  ports                             transfer
// input    req_type, message_byte            push && !full
// result   digest_block, block_index, last_block   pop && !empty
//
// absorb bytes are taken one per cycle while full is low; every eighth byte hands a
// block to the permutation unit, which runs one round per cycle
// finish: a permutation precedes each of the four digest blocks, then the iv state is rebuilt
// after reset the unit first computes the iv state; items queue meanwhile
// full rises while the command queue is full; a held result stalls the next digest block

module ascon_hash256_sponge_top #(
	parameter int CmdDepth = ahs_pkg::AHS_CMD_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [7:0]  message_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      digest_block,
	output logic [1:0]       block_index,
	output logic             last_block
);
	import ahs_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_valid, cmd_pop;
	logic res_valid;
	res_t res_data;

	ahs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.message_byte(message_byte),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd_data(cmd_in)
	);

	ahs_cmd_fifo #(.DEPTH(CmdDepth)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data(cmd_in),
		.full(cmd_full),
		.rd_valid(cmd_valid),
		.rd_data(cmd_out),
		.rd_en(cmd_pop)
	);

	ahs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_data(cmd_out),
		.cmd_pop(cmd_pop),
		.res_valid(res_valid),
		.res_data(res_data),
		.res_pop(pop)
	);

	assign empty = !res_valid;
	assign digest_block = res_data.digest;
	assign block_index = res_data.index;
	assign last_block = res_data.last;

endmodule

`default_nettype wire

@@ rtl/ahs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ahs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [63:0] digest_block,
	input wire logic [1:0]  block_index,
	input wire logic        last_block
);
	logic [1:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 2'd0;
		end else if (pop && !empty) begin
			exp_q <= exp_q + 2'd1;
		end
	end

	a_flags_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}))
		else $error("full or empty unknown");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_block == (block_index == 2'd3)))
		else $error("last_block does not match block_index");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (block_index == exp_q))
		else $error("digest blocks out of order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digest_block) && $stable(block_index)))
		else $error("stalled result changed");

endmodule

bind ascon_hash256_sponge_top ahs_checker u_ahs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.full(full),
	.empty(empty),
	.pop(pop),
	.digest_block(digest_block),
	.block_index(block_index),
	.last_block(last_block)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	import ahs_pkg::*;

	typedef enum logic {
		REQ_ABSORB = 1'b0,
		REQ_FINISH = 1'b1
	} req_e;

	typedef struct {
		req_e kind;
		logic [7:0] data;
	} hash_req_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic req_type = 1'b0;
	logic [7:0] message_byte = 8'd0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [63:0] digest_block;
	logic [1:0] block_index;
	logic last_block;

	ascon_hash256_sponge_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.message_byte(message_byte),
		.empty(empty),
		.pop(pop),
		.digest_block(digest_block),
		.block_index(block_index),
		.last_block(last_block)
	);

	hash_req_t byte_stream[$];
	res_t digest_due[$];
	state_t sponge_words;
	logic [63:0] rate_word;
	int byte_fill;
	int total_reqs;
	int reqs_taken;
	int errors;
	int cycles;
	int send_gap;
	int recv_gap;
	bit send_calm;
	bit recv_calm;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
		logic [127:0] w;
		w = {v, v} >> n;
		return w[63:0];
	endfunction

	function automatic state_t ascon_p12(input state_t s);
		logic [63:0] x0, x1, x2, x3, x4;
		logic [63:0] t0, t1, t2, t3, t4;
		x0 = s[0];
		x1 = s[1];
		x2 = s[2];
		x3 = s[3];
		x4 = s[4];
		for (int r = 0; r < AHS_ROUNDS; r++) begin
			x2 ^= 64'(240 - 15 * r);
			x0 ^= x4;
			x4 ^= x3;
			x2 ^= x1;
			t0 = ~x0 & x1;
			t1 = ~x1 & x2;
			t2 = ~x2 & x3;
			t3 = ~x3 & x4;
			t4 = ~x4 & x0;
			x0 ^= t1;
			x1 ^= t2;
			x2 ^= t3;
			x3 ^= t4;
			x4 ^= t0;
			x1 ^= x0;
			x0 ^= x4;
			x3 ^= x2;
			x2 = ~x2;
			x0 ^= ror64(x0, 19) ^ ror64(x0, 28);
			x1 ^= ror64(x1, 61) ^ ror64(x1, 39);
			x2 ^= ror64(x2, 1) ^ ror64(x2, 6);
			x3 ^= ror64(x3, 10) ^ ror64(x3, 17);
			x4 ^= ror64(x4, 7) ^ ror64(x4, 41);
		end
		return {x4, x3, x2, x1, x0};
	endfunction

	task automatic sponge_clear();
		sponge_words = ascon_p12(AHS_IV_STATE);
		rate_word = 64'd0;
		byte_fill = 0;
	endtask

	task automatic sponge_step(input req_e kind, input logic [7:0] data);
		res_t part;
		if (kind == REQ_ABSORB) begin
			rate_word |= 64'(data) << (8 * byte_fill);
			byte_fill++;
			if (byte_fill == 8) begin
				sponge_words[0] ^= rate_word;
				sponge_words = ascon_p12(sponge_words);
				rate_word = 64'd0;
				byte_fill = 0;
			end
		end else begin
			sponge_words[0] ^= rate_word ^ (64'(AHS_PAD_BYTE) << (8 * byte_fill));
			for (int k = 0; k < 4; k++) begin
				sponge_words = ascon_p12(sponge_words);
				part.digest = sponge_words[0];
				part.index = 2'(k);
				part.last = (2'(k) == AHS_LAST_INDEX);
				digest_due.push_back(part);
			end
			sponge_clear();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic int pick_wait(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic add_req(input req_e kind, input logic [7:0] data);
		hash_req_t r;
		r.kind = kind;
		r.data = data;
		byte_stream.push_back(r);
	endtask

	task automatic add_message(input int len);
		for (int i = 0; i < len; i++)
			add_req(REQ_ABSORB, 8'($urandom_range(0, 255)));
		add_req(REQ_FINISH, 8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin : drive
		bit take_next;
		hash_req_t cur;
		if (arst_n) begin
			take_next = !push;
			if (push && !full) begin
				sponge_step(req_e'(req_type), message_byte);
				reqs_taken++;
				take_next = 1'b1;
			end
			if (take_next) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (byte_stream.size() > 0) begin
					cur = byte_stream.pop_front();
					push <= 1'b1;
					req_type <= cur.kind;
					message_byte <= cur.data;
					send_gap = pick_wait(send_calm);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (digest_due.size() == 0) begin
					flag_mismatch("unexpected transfer", digest_block, 64'd0);
				end else begin
					want = digest_due.pop_front();
					if (digest_block !== want.digest)
						flag_mismatch("digest_block", digest_block, want.digest);
					if (block_index !== want.index)
						flag_mismatch("block_index", 64'(block_index), 64'(want.index));
					if (last_block !== want.last)
						flag_mismatch("last_block", 64'(last_block), 64'(want.last));
				end
				recv_gap = pick_wait(recv_calm);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int len;
		sponge_clear();

		// empty message, ignored byte on finish
		add_req(REQ_FINISH, 8'hA5);
		add_req(REQ_ABSORB, 8'h00);
		add_req(REQ_ABSORB, 8'hFF);
		add_req(REQ_FINISH, 8'hFF);
		// one whole block, pad lands in a fresh block
		for (int i = 0; i < 8; i++)
			add_req(REQ_ABSORB, 8'(1 << i));
		add_req(REQ_FINISH, 8'h00);
		// seven bytes, pad in the top byte
		for (int i = 0; i < 7; i++)
			add_req(REQ_ABSORB, 8'hFF);
		add_req(REQ_FINISH, 8'h5A);

		while (byte_stream.size() < 190) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 17);
			add_message(len);
		end
		total_reqs = byte_stream.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs_taken < total_reqs)
			@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (digest_due.size() != 0)
			flag_mismatch("results left over", 64'(digest_due.size()), 64'd0);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
